// ===== hw/rtl/wgm_pkg.sv =====
// Shared types, constants and sizes for the wildcard glob matcher.
`timescale 1ns / 1ps
`default_nettype none
package wgm_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W       = $clog2(PATTERN_MAX);
    localparam int SET_W       = PATTERN_MAX + 1;

    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] SYM_STAR = 8'h2A;
    localparam logic [7:0] SYM_ANY  = 8'h3F;
    localparam logic [7:0] FOLD_LO  = 8'h41;
    localparam logic [7:0] FOLD_HI  = 8'h5A;
    localparam logic [7:0] FOLD_OFS = 8'h20;

    typedef enum logic [1:0] {
        OP_PAT_CHAR  = 2'd0,
        OP_PAT_END   = 2'd1,
        OP_TEXT_CHAR = 2'd2,
        OP_TEXT_END  = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] sym;
    } t_item;

    // Head of the queue as seen by the back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

endpackage
`default_nettype wire

// ===== hw/rtl/wgm_front.sv =====
// Front end: accepts transactions, decodes the operation and folds the symbol.
`timescale 1ns / 1ps
`default_nettype none
module wgm_front
    import wgm_pkg::*;
(
    input  wire logic       i_valid,
    input  wire logic [1:0] i_operation,
    input  wire logic [7:0] i_symbol,
    input  wire logic       i_q_full,
    output logic            o_stall,
    output logic            o_push,
    output t_item           o_item
);

    logic [7:0] folded;

    always_comb begin
        // Only A-Z fold; '*' and '?' are untouched by this
        if (i_symbol >= FOLD_LO && i_symbol <= FOLD_HI) begin
            folded = i_symbol + FOLD_OFS;
        end else begin
            folded = i_symbol;
        end
    end

    assign o_stall     = i_q_full;
    assign o_push      = i_valid && !i_q_full;
    assign o_item.op   = t_op'(i_operation);
    assign o_item.sym  = folded;

endmodule
`default_nettype wire

// ===== hw/rtl/wgm_queue.sv =====
// Short FIFO between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module wgm_queue
    import wgm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_item      i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_q_head    o_head
);

    t_item               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr, n_wr;
    logic [Q_PTR_W-1:0]  r_rd, n_rd;
    logic [Q_CNT_W-1:0]  r_count, n_count;
    logic                do_push, do_pop;

    assign o_full      = (r_count == Q_CNT_W'(Q_DEPTH));
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/wgm_back.sv =====
// Back end: pattern store, active-position automaton and result register.
`timescale 1ns / 1ps
`default_nettype none
module wgm_back
    import wgm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  t_q_head    i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  wire logic  i_stall,
    output logic       o_matched,
    output logic       o_pattern_error
);

    logic [7:0]        r_store [PATTERN_MAX];
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_ovf, n_ovf;
    logic              r_loading, n_loading;
    logic [SET_W-1:0]  r_active, n_active;
    // Rearm set: position zero plus the run of leading stars
    logic [SET_W-1:0]  r_home, n_home;
    logic              r_out_valid, n_out_valid;
    logic              r_match, n_match;
    logic              r_perr, n_perr;

    logic              out_free;
    logic              fire;
    logic [LEN_W-1:0]  eff_len;
    logic [SET_W-1:0]  eff_home;
    logic              wr_en;
    logic [PATTERN_MAX-1:0] star_m;
    logic [PATTERN_MAX-1:0] hit_m;
    logic [SET_W-1:0]  base;
    logic [SET_W-1:0]  step;
    logic [SET_W-1:0]  stars;
    logic [SET_W-1:0]  closed;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = i_head.valid && ((i_head.item.op != OP_TEXT_END) || out_free);
    assign fire     = o_pop;

    // A pattern character after text starts a fresh load
    assign eff_len  = r_loading ? r_len : '0;
    assign eff_home = r_loading ? r_home : SET_W'(1);
    assign wr_en    = fire && (i_head.item.op == OP_PAT_CHAR)
                      && (eff_len < LEN_W'(PATTERN_MAX));

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            star_m[i] = (LEN_W'(i) < r_len) && (r_store[i] == SYM_STAR);
            hit_m[i]  = (LEN_W'(i) < r_len)
                        && ((r_store[i] == SYM_ANY) || (r_store[i] == i_head.item.sym));
        end
    end

    assign base  = r_loading ? r_home : r_active;
    assign stars = {1'b0, star_m};

    always_comb begin
        step = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (base[i] && star_m[i]) begin
                step[i] = 1'b1;
            end else if (base[i] && hit_m[i]) begin
                step[i+1] = 1'b1;
            end
        end
    end

    // Carry through each run of stars: an active star lights every position
    // up to and including the first non-star after the run
    assign closed = step | (((step & stars) + stars) ^ stars);

    always_comb begin
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_loading   = r_loading;
        n_active    = r_active;
        n_home      = r_home;
        n_match     = r_match;
        n_perr      = r_perr;
        n_out_valid = r_out_valid && i_stall;
        if (fire) begin
            case (i_head.item.op)
                OP_PAT_CHAR: begin
                    n_loading = 1'b1;
                    n_len     = eff_len;
                    n_ovf     = r_loading ? r_ovf : 1'b0;
                    n_home    = eff_home;
                    if (eff_len < LEN_W'(PATTERN_MAX)) begin
                        n_len = eff_len + 1'b1;
                        if (eff_home[eff_len] && (i_head.item.sym == SYM_STAR)) begin
                            for (int j = 1; j < SET_W; j++) begin
                                if (LEN_W'(j) == eff_len + 1'b1) begin
                                    n_home[j] = 1'b1;
                                end
                            end
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                OP_PAT_END: begin
                    n_loading = 1'b0;
                    n_active  = r_home;
                end
                OP_TEXT_CHAR: begin
                    n_loading = 1'b0;
                    n_active  = closed;
                end
                OP_TEXT_END: begin
                    n_loading   = 1'b0;
                    n_active    = r_home;
                    n_out_valid = 1'b1;
                    n_match     = !r_ovf && base[r_len];
                    n_perr      = r_ovf;
                end
                default: begin
                    n_loading = r_loading;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_loading   <= 1'b1;
            r_active    <= SET_W'(1);
            r_home      <= SET_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_ovf       <= n_ovf;
            r_loading   <= n_loading;
            r_active    <= n_active;
            r_home      <= n_home;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_match <= n_match;
        r_perr  <= n_perr;
        if (wr_en) begin
            r_store[eff_len[IDX_W-1:0]] <= i_head.item.sym;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_matched       = r_match;
    assign o_pattern_error = r_perr;

`ifndef SYNTHESIS
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_head.item.op == OP_TEXT_END) |=> r_out_valid)
        else $error("text end did not load the result register");
    a_error_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_perr) |-> !r_match)
        else $error("pattern error reported together with a match");
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(PATTERN_MAX))
        else $error("pattern length beyond the store");
    a_home_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_home[0])
        else $error("rearm set lost position zero");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/wildcard_glob_matcher.sv =====
// Top level of the wildcard glob matcher.
`timescale 1ns / 1ps
`default_nettype none
// Case-insensitive glob matcher ('*' any run, '?' one byte, only A-Z folded).
// Load a pattern one character per transaction, close it with a pattern end,
// then stream text characters and finish with a text end, which yields one
// result transaction (matched, pattern_error). Patterns longer than
// PATTERN_MAX characters are truncated and flagged; every text end then reports
// pattern_error. A pattern character sent after text starts a new pattern; a
// pattern end during text drops that text. The block sustains one transaction
// per cycle when nothing stalls: every pattern position updates in parallel,
// with a single carry chain resolving runs of stars. A four-entry queue sits
// between the input decode and the automaton, so a text end passes through the
// queue and then the result register, which holds the result while input keeps
// flowing.
module wildcard_glob_matcher
    import wgm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_operation,
    input  wire logic [7:0] i_symbol,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_matched,
    output logic            o_pattern_error
);

    logic    q_full;
    logic    q_push;
    logic    q_pop;
    t_item   q_item;
    t_q_head q_head;

    wgm_front u_front (
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_symbol    (i_symbol),
        .i_q_full    (q_full),
        .o_stall     (o_stall),
        .o_push      (q_push),
        .o_item      (q_item)
    );

    wgm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    wgm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (q_head),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_matched       (o_matched),
        .o_pattern_error (o_pattern_error)
    );

endmodule
`default_nettype wire
